FILE: hdl/ir_carrier_uart_transmitter_assert.svh
// ----------------------------------------------------------------------------
// ir carrier uart transmitter assertion macros
// concurrent checks used by the top level, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef IR_CARRIER_UART_TRANSMITTER_ASSERT_SVH
`define IR_CARRIER_UART_TRANSMITTER_ASSERT_SVH

// same-cycle implication, held off while reset is asserted
`define IRTX_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is asserted
`define IRTX_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/irtx_pkg.sv
// ----------------------------------------------------------------------------
// irtx_pkg
// shared types and constants of the ir carrier uart transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package irtx_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned PULSES_W    = 7;
  localparam int unsigned HALF_W      = 16;
  localparam int unsigned PULSE_CNT_W = 6;
  localparam int unsigned TICK_CNT_W  = 16;
  localparam int unsigned BIT_POS_W   = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PULSES_W-1:0] PULSES_RESET = 7'd16;
  localparam logic [PULSES_W-1:0] PULSES_MAX   = 7'd64;
  localparam logic [HALF_W-1:0]   HALF_RESET   = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSES_PER_BIT     = 1'b0,
    CFG_CARRIER_HALF_TICKS = 1'b1
  } irtx_cfg_e;

  typedef enum logic [0:0] {
    CMD_TICK  = 1'b0,
    CMD_OFFER = 1'b1
  } irtx_cmd_e;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] byte_value;
  } irtx_in_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } irtx_out_t;

  // classified item held in the queue between front and back
  typedef struct packed {
    irtx_cmd_e         kind;
    logic [BYTE_W-1:0] data;
  } irtx_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/ir_carrier_uart_transmitter.sv
// ----------------------------------------------------------------------------
// ir_carrier_uart_transmitter
// 8n1 uart framing sent as a burst-modulated infrared carrier
// ----------------------------------------------------------------------------
// Every input item (a tick or an offered byte) yields one result item. The
// block takes one item per clock cycle while the output does not stall:
// items go through a two-entry queue into the frame sequencer, which updates
// its counters and the LED level for one item per cycle and loads the result
// register, so an item's result is on the outputs from the clock edge after
// the one that accepted it when nothing stalls.
// Output stalls back up into the queue and then into in_stall_o. Registers
// are pulses_per_bit (index 0) and carrier_half_ticks (index 1); the user
// writes them only with no item in flight, which the block does not enforce.
`default_nettype none

module ir_carrier_uart_transmitter #(
  parameter int unsigned DATA_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [irtx_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [irtx_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire irtx_pkg::irtx_in_t                in_item_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      irtx_pkg::irtx_out_t               out_item_o
);
  import irtx_pkg::*;

  `include "ir_carrier_uart_transmitter_assert.svh"

  logic [PULSES_W-1:0] pulses_q, pulses_d;
  logic [HALF_W-1:0]   half_ticks_q, half_ticks_d;
  logic                q_valid;
  irtx_cmd_t           q_item;
  logic                q_pop;

  always_comb begin
    pulses_d     = pulses_q;
    half_ticks_d = half_ticks_q;
    if (cfg_we_i) begin
      case (irtx_cfg_e'(cfg_index_i))
        CFG_PULSES_PER_BIT:     pulses_d     = cfg_data_i[PULSES_W-1:0];
        CFG_CARRIER_HALF_TICKS: half_ticks_d = cfg_data_i[HALF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulses_q     <= PULSES_RESET;
      half_ticks_q <= HALF_RESET;
    end else begin
      pulses_q     <= pulses_d;
      half_ticks_q <= half_ticks_d;
    end
  end

  irtx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  irtx_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .pulses_per_bit_i     (pulses_q),
    .carrier_half_ticks_i (half_ticks_q),
    .q_valid_i            (q_valid),
    .q_item_i             (q_item),
    .q_pop_o              (q_pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_item_o           (out_item_o)
  );

  // a full queue is still non-empty in the next cycle
  `IRTX_ASSERT_NEXT(a_full_then_valid, clk_i, rst_ni, in_stall_o, q_valid,
                    "queue emptied while full")

  // a frame end leaves the transmitter idle with the led off
  `IRTX_ASSERT_IMPLIES(a_done_idle, clk_i, rst_ni,
                       out_valid_o && out_item_o.frame_done,
                       !out_item_o.busy_res && !out_item_o.ir_level,
                       "frame end not idle")

  // a taken byte starts the start bit at once
  `IRTX_ASSERT_IMPLIES(a_accept_start, clk_i, rst_ni,
                       out_valid_o && out_item_o.accepted,
                       out_item_o.busy_res && out_item_o.ir_level && !out_item_o.frame_done,
                       "start bit missing")

  // the led is only ever on during a frame
  `IRTX_ASSERT_IMPLIES(a_idle_dark, clk_i, rst_ni,
                       out_valid_o && !out_item_o.busy_res,
                       !out_item_o.ir_level,
                       "led on while idle")

endmodule

`default_nettype wire

FILE: hdl/irtx_front.sv
// ----------------------------------------------------------------------------
// irtx_front
// accepts input items, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module irtx_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire irtx_pkg::irtx_in_t in_item_i,
  output      logic               q_valid_o,
  output      irtx_pkg::irtx_cmd_t q_item_o,
  input  wire logic               q_pop_i
);
  import irtx_pkg::*;

  irtx_cmd_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]     count_q, count_d;
  logic                  push;
  logic                  pop;
  irtx_cmd_t             cls_item;

  assign in_stall_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    cls_item.kind = (in_item_i.command == 1'b1) ? CMD_OFFER : CMD_TICK;
    cls_item.data = in_item_i.byte_value;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/irtx_back.sv
// ----------------------------------------------------------------------------
// irtx_back
// frame sequencer: carrier timing, bit shifting and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module irtx_back #(
  parameter int unsigned DATA_BITS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [irtx_pkg::PULSES_W-1:0]    pulses_per_bit_i,
  input  wire logic [irtx_pkg::HALF_W-1:0]      carrier_half_ticks_i,
  input  wire logic                             q_valid_i,
  input  wire irtx_pkg::irtx_cmd_t              q_item_i,
  output      logic                             q_pop_o,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      irtx_pkg::irtx_out_t              out_item_o
);
  import irtx_pkg::*;

  localparam int unsigned FRAME_BITS = DATA_BITS + 2;

  logic [FRAME_BITS-1:0]  frame_q, frame_d;
  logic [BIT_POS_W-1:0]   bit_pos_q, bit_pos_d;
  logic [PULSE_CNT_W-1:0] pulse_cnt_q, pulse_cnt_d;
  logic                   half_q, half_d;
  logic [TICK_CNT_W-1:0]  tick_cnt_q, tick_cnt_d;
  logic                   active_q, active_d;
  logic                   led_q, led_d;
  logic                   out_valid_q, out_valid_d;
  irtx_out_t              out_q, out_d;

  logic [PULSES_W-1:0]    eff_pulses;
  logic [HALF_W-1:0]      eff_half;
  logic [2*BYTE_W-1:0]    data_ext;
  logic [FRAME_BITS-1:0]  frame_new;
  logic [BIT_POS_W-1:0]   bit_pos_inc;
  logic                   pop;
  logic                   acc;
  logic                   done;

  // result register frees when empty or when its item is being taken
  assign pop     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = pop;

  assign eff_pulses = (pulses_per_bit_i == '0) ? PULSES_W'(1) :
                      (pulses_per_bit_i > PULSES_MAX) ? PULSES_MAX : pulses_per_bit_i;
  assign eff_half   = (carrier_half_ticks_i == '0) ? HALF_W'(1) : carrier_half_ticks_i;

  // data bits above the byte width read as zero
  assign data_ext    = {{BYTE_W{1'b0}}, q_item_i.data};
  assign frame_new   = {1'b1, data_ext[DATA_BITS-1:0], 1'b0};
  assign bit_pos_inc = bit_pos_q + BIT_POS_W'(1);

  always_comb begin
    frame_d     = frame_q;
    bit_pos_d   = bit_pos_q;
    pulse_cnt_d = pulse_cnt_q;
    half_d      = half_q;
    tick_cnt_d  = tick_cnt_q;
    active_d    = active_q;
    led_d       = led_q;
    acc         = 1'b0;
    done        = 1'b0;
    if (pop) begin
      case (q_item_i.kind)
        CMD_OFFER: begin
          if (!active_q) begin
            frame_d     = frame_new;
            bit_pos_d   = '0;
            pulse_cnt_d = '0;
            half_d      = 1'b0;
            tick_cnt_d  = '0;
            active_d    = 1'b1;
            acc         = 1'b1;
            led_d       = !frame_new[0];
          end
        end
        CMD_TICK: begin
          if (active_q) begin
            if (({1'b0, tick_cnt_q} + (TICK_CNT_W + 1)'(1)) >= {1'b0, eff_half}) begin
              tick_cnt_d = '0;
              if (!half_q) begin
                half_d = 1'b1;
              end else begin
                half_d = 1'b0;
                if (({1'b0, pulse_cnt_q} + PULSES_W'(1)) >= eff_pulses) begin
                  pulse_cnt_d = '0;
                  frame_d     = {1'b1, frame_q[FRAME_BITS-1:1]};
                  bit_pos_d   = bit_pos_inc;
                  // stop bit finished
                  if (bit_pos_inc >= BIT_POS_W'(FRAME_BITS)) begin
                    active_d  = 1'b0;
                    bit_pos_d = '0;
                    frame_d   = '1;
                    done      = 1'b1;
                  end
                end else begin
                  pulse_cnt_d = pulse_cnt_q + PULSE_CNT_W'(1);
                end
              end
            end else begin
              tick_cnt_d = tick_cnt_q + TICK_CNT_W'(1);
            end
            led_d = active_d && !frame_d[0] && !half_d;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_d.ir_level   = led_d;
    out_d.busy_res   = active_d;
    out_d.accepted   = acc;
    out_d.frame_done = done;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '1;
      bit_pos_q   <= '0;
      pulse_cnt_q <= '0;
      half_q      <= 1'b0;
      tick_cnt_q  <= '0;
      active_q    <= 1'b0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      frame_q     <= frame_d;
      bit_pos_q   <= bit_pos_d;
      pulse_cnt_q <= pulse_cnt_d;
      half_q      <= half_d;
      tick_cnt_q  <= tick_cnt_d;
      active_q    <= active_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
